// ----- hdl/lsbe_pkg.sv -----
// Package of the LED strip bit encoder: constants, register codes and shared types.
package lsbe_pkg;

  // Field widths.
  localparam int COLOR_W  = 24;
  localparam int DUTY_W   = 8;
  localparam int PCOUNT_W = 11;
  localparam int PIDX_W   = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;

  // Frame shape.
  localparam int BITS_PER_PIXEL = 24;
  localparam int RESET_SLOTS    = 40;
  localparam int MAX_PIXELS     = 1024;
  localparam int SLOTS_TOTAL    = BITS_PER_PIXEL + RESET_SLOTS;
  localparam int SLOT_W         = $clog2(SLOTS_TOTAL);

  // Reset values of the configuration registers.
  localparam logic [PCOUNT_W-1:0] PIXEL_COUNT_RST = PCOUNT_W'(1);
  localparam logic                CHANNEL_ORDER_RST = 1'b0;
  localparam logic [DUTY_W-1:0]   DUTY_ONE_RST  = DUTY_W'(14);
  localparam logic [DUTY_W-1:0]   DUTY_ZERO_RST = DUTY_W'(7);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_COUNT   = 2'd0,
    REG_CHANNEL_ORDER = 2'd1,
    REG_DUTY_ONE      = 2'd2,
    REG_DUTY_ZERO     = 2'd3
  } cfg_reg_e;

  // Channel order codes.
  typedef enum logic {
    ORDER_R_B_G = 1'b0,
    ORDER_R_G_B = 1'b1
  } chan_order_e;

  // Status of the slot at the head of the serializer.
  typedef struct packed {
    logic valid;
    logic data_bit;
    logic reset_slot;
    logic last;
    logic frame_end;
  } slot_t;

  // Puts the three bytes into transmit order, first byte in the top bits.
  function automatic logic [COLOR_W-1:0] reorder(input logic [COLOR_W-1:0] color,
                                                 input logic order);
    logic [COLOR_W-1:0] res;
    if (order == ORDER_R_G_B) begin
      res = color;
    end else begin
      res = {color[23:16], color[7:0], color[15:8]};
    end
    return res;
  endfunction

endpackage

// ----- hdl/lsbe_slot_gen.sv -----
// Slot serializer: shifts one pixel out bit by bit, then the reset slots if it ends a frame.
module lsbe_slot_gen
  import lsbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [COLOR_W-1:0] load_bits_i,
  input  logic               load_ends_i,
  input  logic               advance_i,
  output slot_t              slot_o,
  output logic               can_load_o
);

  logic [COLOR_W-1:0] bits_q, bits_d;
  logic [SLOT_W-1:0]  cnt_q, cnt_d;
  logic               ends_q, ends_d;
  logic               busy_q, busy_d;
  logic               at_last;

  // Head slot decode.
  always_comb begin
    if (ends_q) begin
      at_last = (cnt_q == SLOT_W'(SLOTS_TOTAL - 1));
    end else begin
      at_last = (cnt_q == SLOT_W'(BITS_PER_PIXEL - 1));
    end
    slot_o.valid      = busy_q;
    slot_o.data_bit   = bits_q[COLOR_W-1];
    slot_o.reset_slot = (cnt_q >= SLOT_W'(BITS_PER_PIXEL));
    slot_o.last       = at_last;
    slot_o.frame_end  = ends_q && at_last;
  end

  // A new pixel may enter while idle, or as the final slot of the current one leaves.
  assign can_load_o = !busy_q || (advance_i && at_last);

  // Next state of the serializer.
  always_comb begin
    bits_d = bits_q;
    cnt_d  = cnt_q;
    ends_d = ends_q;
    busy_d = busy_q;
    if (load_i) begin
      bits_d = load_bits_i;
      cnt_d  = '0;
      ends_d = load_ends_i;
      busy_d = 1'b1;
    end else if (advance_i && busy_q) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d  = cnt_q + SLOT_W'(1);
        bits_d = {bits_q[COLOR_W-2:0], 1'b0};
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ends_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ends_q <= ends_d;
    end
  end

  // Pixel shift register.
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

endmodule

// ----- hdl/led_strip_bit_encoder.sv -----
// Top level of the LED strip bit encoder: configuration, frame counter and output register.
//
//   port group   direction  handshake                 payload
//   input word   in         in_valid_i / in_ready_o   pixel_color_i
//   output word  out        out_valid_o / out_ready_i duty_o, last_of_run_o, frame_end_o
//   config       in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// Each pixel gives 24 output words, one a cycle while the output does not stall, plus
// 40 reset words when it ends a frame; the slot counter of the serializer sets that
// figure. The next pixel is taken in the cycle its predecessor's final word moves to
// the output register, so pixels stream with no gap. Reset clears the frame counter,
// the serializer and the output valid, and loads the configuration defaults. A stalled
// output holds its word and the serializer waits with it.
module led_strip_bit_encoder
  import lsbe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [COLOR_W-1:0]   pixel_color_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DUTY_W-1:0]    duty_o,
  output logic                 last_of_run_o,
  output logic                 frame_end_o
);

  logic [PCOUNT_W-1:0] pixel_count_q;
  logic                channel_order_q;
  logic [DUTY_W-1:0]   duty_one_q, duty_zero_q;
  logic [PIDX_W-1:0]   pixel_index_q, pixel_index_d;
  logic [PCOUNT_W-1:0] frame_len;
  logic [PCOUNT_W-1:0] next_pos;
  logic                ends;
  logic                accept;
  logic                advance;
  logic                can_load;
  slot_t               slot;
  logic                out_valid_q;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic                last_q, fend_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q   <= PIXEL_COUNT_RST;
      channel_order_q <= CHANNEL_ORDER_RST;
      duty_one_q      <= DUTY_ONE_RST;
      duty_zero_q     <= DUTY_ZERO_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PIXEL_COUNT:   pixel_count_q   <= cfg_wdata_i[PCOUNT_W-1:0];
        REG_CHANNEL_ORDER: channel_order_q <= cfg_wdata_i[0];
        REG_DUTY_ONE:      duty_one_q      <= cfg_wdata_i[DUTY_W-1:0];
        REG_DUTY_ZERO:     duty_zero_q     <= cfg_wdata_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame length clamped to one..maximum, and the end-of-frame test.
  always_comb begin
    if (pixel_count_q == '0) begin
      frame_len = PCOUNT_W'(1);
    end else if (pixel_count_q > PCOUNT_W'(MAX_PIXELS)) begin
      frame_len = PCOUNT_W'(MAX_PIXELS);
    end else begin
      frame_len = pixel_count_q;
    end
    next_pos = PCOUNT_W'(pixel_index_q) + PCOUNT_W'(1);
    ends     = (next_pos >= frame_len);
    pixel_index_d = ends ? '0 : next_pos[PIDX_W-1:0];
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = can_load;
  assign advance    = slot.valid && (!out_valid_q || out_ready_i);

  // Pixel position within the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_index_q <= '0;
    end else if (accept) begin
      pixel_index_q <= pixel_index_d;
    end
  end

  lsbe_slot_gen u_slot_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .load_bits_i (reorder(pixel_color_i, channel_order_q)),
    .load_ends_i (ends),
    .advance_i   (advance),
    .slot_o      (slot),
    .can_load_o  (can_load)
  );

  // Duty of the head slot.
  always_comb begin
    if (slot.reset_slot) begin
      duty_d = '0;
    end else if (slot.data_bit) begin
      duty_d = duty_one_q;
    end else begin
      duty_d = duty_zero_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_q <= duty_d;
      last_q <= slot.last;
      fend_q <= slot.frame_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_o        = duty_q;
  assign last_of_run_o = last_q;
  assign frame_end_o   = fend_q;

  // The end of a frame is always the final word of its pixel.
  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_of_run_o)
    else $error("frame end without last of run");

  // No new pixel is taken while the current one still has words beyond the head.
  a_no_early_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot.valid && !slot.last |-> !in_ready_o)
    else $error("pixel accepted mid-run");

  // The closing word of a frame is a zero-duty reset slot.
  a_fend_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o && (RESET_SLOTS > 0) |-> duty_o == '0)
    else $error("frame end word is not a reset slot");

endmodule

// ----- test/lsbe_checker.sv -----
// Checker of the LED strip bit encoder: predicts the slot words of each pixel and compares them.
module lsbe_checker
  import lsbe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [COLOR_W-1:0]   pixel_color_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DUTY_W-1:0]    duty_i,
  input  logic                 last_of_run_i,
  input  logic                 frame_end_i,
  output int                   pending_o,
  output int                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output word.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              last_of_run;
    logic              frame_end;
  } slot_word_t;

  slot_word_t slot_words_q[$];

  // Own copy of the configuration and of the frame position.
  logic [PCOUNT_W-1:0] pix_count;
  chan_order_e         order;
  logic [DUTY_W-1:0]   duty_one;
  logic [DUTY_W-1:0]   duty_zero;
  logic [PIDX_W-1:0]   pix_index;
  int                  fails;

  // Queues the bit slots of one pixel, and the latch gap when the pixel ends a frame.
  task automatic encode_pixel(input logic [COLOR_W-1:0] color);
    logic [COLOR_W-1:0] ordered;
    int                 frame_len;
    logic               ends;
    int                 total;
    slot_word_t         w;
    if (order == ORDER_R_G_B) begin
      ordered = color;
    end else begin
      ordered = {color[23:16], color[7:0], color[15:8]};
    end
    frame_len = int'(pix_count);
    if (frame_len < 1) frame_len = 1;
    if (frame_len > MAX_PIXELS) frame_len = MAX_PIXELS;
    ends  = (int'(pix_index) + 1) >= frame_len;
    total = ends ? BITS_PER_PIXEL + RESET_SLOTS : BITS_PER_PIXEL;
    for (int k = 0; k < total; k++) begin
      if (k < BITS_PER_PIXEL) begin
        w.duty = ordered[BITS_PER_PIXEL-1-k] ? duty_one : duty_zero;
      end else begin
        w.duty = '0;
      end
      w.last_of_run = (k == total - 1);
      w.frame_end   = ends && (k == total - 1);
      slot_words_q.push_back(w);
    end
    pix_index = ends ? '0 : pix_index + 1'b1;
  endtask

  // Watch the three ports at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    slot_word_t want;
    if (!rst_ni) begin
      pix_count = PIXEL_COUNT_RST;
      order     = chan_order_e'(CHANNEL_ORDER_RST);
      duty_one  = DUTY_ONE_RST;
      duty_zero = DUTY_ZERO_RST;
      pix_index = '0;
      fails     = 0;
      slot_words_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Compare an accepted output word with the oldest expectation.
      if (out_valid_i && out_ready_i) begin
        if (slot_words_q.size() == 0) begin
          $error("unexpected output word: duty %0d, last_of_run %0b, frame_end %0b",
                 duty_i, last_of_run_i, frame_end_i);
          fails++;
        end else begin
          want = slot_words_q.pop_front();
          if (duty_i !== want.duty) begin
            $error("duty mismatch: expected %0d, actual %0d", want.duty, duty_i);
            fails++;
          end
          if (last_of_run_i !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   want.last_of_run, last_of_run_i);
            fails++;
          end
          if (frame_end_i !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b",
                   want.frame_end, frame_end_i);
            fails++;
          end
        end
      end
      // Predict the words of an accepted pixel.
      if (in_valid_i && in_ready_i) begin
        encode_pixel(pixel_color_i);
      end
      // Register writes take effect at the edge that carries them.
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PIXEL_COUNT:   pix_count = cfg_wdata_i[PCOUNT_W-1:0];
          REG_CHANNEL_ORDER: order     = chan_order_e'(cfg_wdata_i[0]);
          REG_DUTY_ONE:      duty_one  = cfg_wdata_i[DUTY_W-1:0];
          REG_DUTY_ZERO:     duty_zero = cfg_wdata_i[DUTY_W-1:0];
          default: ;
        endcase
      end
      pending_o    <= slot_words_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top of the LED strip bit encoder: clock, reset, stimulus and verdict.
module tb_top
  import lsbe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 500;
  localparam int PHASE_ITEMS  = 70;
  localparam int PHASES       = 6;
  localparam int SETTLE_TICKS = 8;
  localparam int END_TICKS    = 100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [COLOR_W-1:0]   pixel_color_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [DUTY_W-1:0]    duty_o;
  logic                 last_of_run_o;
  logic                 frame_end_o;

  int   pending_words;
  int   fail_count;
  int   cycle_count = 0;
  logic quiet_mode = 1'b0;
  logic hold_off_req = 1'b0;

  led_strip_bit_encoder u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .pixel_color_i,
    .out_valid_o, .out_ready_i, .duty_o, .last_of_run_o, .frame_end_o
  );

  lsbe_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i (in_ready_o), .pixel_color_i,
    .out_valid_i (out_valid_o), .out_ready_i, .duty_i (duty_o),
    .last_of_run_i (last_of_run_o), .frame_end_i (frame_end_o),
    .pending_o (pending_words), .fail_count_o (fail_count)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none in quiet mode.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= quiet_mode || ($urandom_range(99) >= 25);
    end
  end

  // Writes one register; the block is idle whenever this is called.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Offers one pixel word, possibly after a gap, and waits until it is taken.
  task automatic send_pixel(input logic [COLOR_W-1:0] color);
    @(negedge clk_i);
    if (!quiet_mode && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_color_i <= color;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering and waits until every expected word has come out.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_words == 0);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  // Random color, with whole bytes at their extremes now and then.
  function automatic logic [COLOR_W-1:0] rand_color();
    logic [COLOR_W-1:0] c;
    c = COLOR_W'($urandom());
    for (int b = 0; b < 3; b++) begin
      case ($urandom_range(7))
        0: c[b*8 +: 8] = 8'h00;
        1: c[b*8 +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return c;
  endfunction

  initial begin
    int count;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults: every pixel ends a frame.
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
    send_pixel(24'hA5C33C);
    drain();

    // Other order, extreme duties; high data bits must be ignored.
    write_reg(REG_CHANNEL_ORDER, 11'h7FF);
    write_reg(REG_DUTY_ONE, 11'h7FF);
    write_reg(REG_DUTY_ZERO, 11'h700);
    send_pixel(24'h123456);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h800001);
    drain();

    // A pixel count of zero acts as one.
    write_reg(REG_PIXEL_COUNT, 11'd0);
    send_pixel(24'h0F0F0F);
    send_pixel(24'hF0F0F0);
    drain();

    // A count above the maximum saturates, so no frame ends here.
    write_reg(REG_PIXEL_COUNT, 11'h7FF);
    write_reg(REG_CHANNEL_ORDER, 11'd0);
    send_pixel(24'h3C5AA5);
    send_pixel(24'hC3A55A);
    send_pixel(24'h010203);
    drain();

    // Count lowered below the current position: the next pixel ends the frame.
    write_reg(REG_PIXEL_COUNT, 11'd2);
    send_pixel(24'h7E8118);
    send_pixel(24'h81007E);
    send_pixel(24'hFFFF00);
    drain();

    // Random phases, each under its own settings.
    for (int p = 0; p < PHASES; p++) begin
      count = (p == 2) ? MAX_PIXELS : $urandom_range(8, 1);
      write_reg(REG_PIXEL_COUNT, CFG_W'(count));
      write_reg(REG_CHANNEL_ORDER, CFG_W'(p % 2));
      write_reg(REG_DUTY_ONE, (p == 1) ? CFG_W'(0) : CFG_W'($urandom_range(255)));
      write_reg(REG_DUTY_ZERO, (p == 1) ? CFG_W'(255) : CFG_W'($urandom_range(255)));
      quiet_mode = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == 10) hold_off_req = 1'b1;
        if (p == 5 && n == 40) begin
          // Let the output catch up completely before going on.
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          wait (pending_words == 0);
        end
        send_pixel(rand_color());
      end
      drain();
      quiet_mode = 1'b0;
    end

    repeat (END_TICKS) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
